// File: rtl/exi_bit_packed_integer_writer_top_macros.svh
// Assertion macros used by the checker file of the bit-packed writer.
`ifndef EXI_BIT_PACKED_INTEGER_WRITER_TOP_MACROS_SVH
`define EXI_BIT_PACKED_INTEGER_WRITER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define EBPIW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that requires a consequence in the next cycle.
`define EBPIW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ebpiw_pkg.sv
// Types and constants shared by the bit-packed integer writer modules.
`timescale 1ns / 1ps

package ebpiw_pkg;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned CountW    = 6;
  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 8;

  localparam int unsigned ActionLsb = 0;
  localparam int unsigned ValueLsb  = 2;
  localparam int unsigned CountLsb  = 66;

  localparam logic [ActionW-1:0] ACT_RAW   = 2'd0;
  localparam logic [ActionW-1:0] ACT_UINT  = 2'd1;
  localparam logic [ActionW-1:0] ACT_SINT  = 2'd2;
  localparam logic [ActionW-1:0] ACT_FLUSH = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RAW,
    OP_SIGN,
    OP_UINT,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic emits;
    logic done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/ebpiw_ctrl.sv
// Controller state machine that sequences the append steps of one action.
`timescale 1ns / 1ps

module ebpiw_ctrl
  import ebpiw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [ActionW-1:0] action_i,
  output logic               in_ready_o,
  input  status_t            sts_i,
  output cmd_t               cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RAW   = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_UINT  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;
  op_e        op;
  logic       step;
  logic       load;

  assign load       = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign step       = (op != OP_NONE) && (!sts_i.emits || sts_i.out_free);

  always_comb begin
    unique case (state_q)
      ST_RAW:   op = OP_RAW;
      ST_SIGN:  op = OP_SIGN;
      ST_UINT:  op = OP_UINT;
      ST_FLUSH: op = OP_FLUSH;
      default:  op = OP_NONE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (load) begin
      unique case (action_i)
        ACT_RAW:  state_d = ST_RAW;
        ACT_UINT: state_d = ST_UINT;
        ACT_SINT: state_d = ST_SIGN;
        default:  state_d = ST_FLUSH;
      endcase
    end else if (step) begin
      if (sts_i.done) begin
        state_d = ST_IDLE;
      end else if (state_q == ST_SIGN) begin
        state_d = ST_UINT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load = load;
  assign cmd_o.op   = op;
  assign cmd_o.step = step;

endmodule

// File: rtl/ebpiw_dp.sv
// Datapath with the bit source registers, the pending byte and the output register.
`timescale 1ns / 1ps

module ebpiw_dp
  import ebpiw_pkg::*;
#(
  parameter int unsigned RAW_WIDTH_MAX = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              sts_o,
  input  logic [ActionW-1:0]   action_i,
  input  logic [ValueW-1:0]    value_i,
  input  logic [CountW-1:0]    raw_len_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutTdataW-1:0] out_byte_o,
  output logic                 out_last_o
);

  localparam int unsigned RW = ($clog2(RAW_WIDTH_MAX + 1) > CountW) ?
                               $clog2(RAW_WIDTH_MAX + 1) : CountW;
  localparam logic [RW-1:0] RawMax = RW'(RAW_WIDTH_MAX);

  logic [RAW_WIDTH_MAX-1:0] src_q;
  logic [RW-1:0]            rem_q;
  logic [ValueW-1:0]        mag_q;
  logic                     sign_q;
  logic [7:0]               pend_q;
  logic [2:0]               fill_q;
  logic                     out_valid_q;
  logic [7:0]               out_byte_q;
  logic                     out_last_q;

  logic [RW-1:0]  count_ext;
  logic [RW-1:0]  count_sat;
  logic [3:0]     room;
  logic           rem_lt;
  logic [3:0]     raw_k;
  logic           more;
  logic [7:0]     nb;
  logic [3:0]     k;
  logic           last;
  logic           done;
  logic [7:0]     nb_m;
  logic [15:0]    comb_w;
  logic [3:0]     total;
  logic           emits;
  logic           out_free;

  assign count_ext = RW'(raw_len_i);
  assign count_sat = (count_ext > RawMax) ? RawMax : count_ext;

  assign room   = 4'd8 - {1'b0, fill_q};
  assign rem_lt = rem_q < RW'(room);
  assign raw_k  = rem_lt ? 4'(rem_q) : room;
  assign more   = |mag_q[ValueW-1:7];

  always_comb begin
    unique case (cmd_i.op)
      OP_RAW: begin
        nb   = src_q[RAW_WIDTH_MAX-1 -: 8];
        k    = raw_k;
        last = (rem_q - RW'(raw_k)) < RW'(8);
        done = (rem_q == RW'(raw_k));
      end
      OP_SIGN: begin
        nb   = {sign_q, 7'd0};
        k    = 4'd1;
        last = 1'b0;
        done = 1'b0;
      end
      OP_UINT: begin
        nb   = {more, mag_q[6:0]};
        k    = 4'd8;
        last = !more;
        done = !more;
      end
      OP_FLUSH: begin
        nb   = 8'd0;
        k    = (fill_q == 3'd0) ? 4'd0 : room;
        last = 1'b1;
        done = 1'b1;
      end
      default: begin
        nb   = 8'd0;
        k    = 4'd0;
        last = 1'b0;
        done = 1'b0;
      end
    endcase
  end

  assign nb_m     = nb & ~(8'hFF >> k);
  assign comb_w   = {pend_q, 8'd0} | ({nb_m, 8'd0} >> fill_q);
  assign total    = {1'b0, fill_q} + k;
  assign emits    = total[3];
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 8'd0;
      fill_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        pend_q <= emits ? comb_w[7:0] : comb_w[15:8];
        fill_q <= total[2:0];
      end
      if (cmd_i.step && emits) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q  <= value_i[RAW_WIDTH_MAX-1:0] << (RawMax - count_sat);
      rem_q  <= count_sat;
      sign_q <= value_i[ValueW-1];
      mag_q  <= (action_i == ACT_SINT && value_i[ValueW-1]) ? (~value_i + 64'd1) : value_i;
    end else if (cmd_i.step) begin
      if (cmd_i.op == OP_RAW) begin
        src_q <= src_q << raw_k;
        rem_q <= rem_q - RW'(raw_k);
      end
      if (cmd_i.op == OP_UINT) begin
        mag_q <= mag_q >> 7;
      end
    end
    if (cmd_i.step && emits) begin
      out_byte_q <= comb_w[15:8];
      out_last_q <= last;
    end
  end

  assign sts_o.emits    = emits;
  assign sts_o.done     = done;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/exi_bit_packed_integer_writer_top.sv
// Top level of the EXI bit-packed integer writer.
// The slave stream takes one action per transfer: raw bits, an unsigned
// integer, a signed integer or a flush of the partial byte. The master
// stream returns the completed bytes, first stream bit in bit 7, with
// tlast set on the final byte that the action produced.
// The input is taken only while no action is in progress. After a transfer
// the controller runs the append steps of the action: one step for each byte
// or partial byte of a raw field, one for each 7-bit group of an integer,
// one more for the sign bit, and one for a flush. A raw field of n bits
// with f bits pending takes (f + n + 7) / 8 steps, one when n is zero, and
// each byte appears in the output register in the cycle after its step.
// The rate is set by the single append unit, which completes at most one
// byte per cycle.
// Reset clears the pending partial byte and the output valid flag. When the
// receiver stalls, the output register holds its byte and a step that
// would complete another byte waits; steps that complete no byte go on.
`timescale 1ns / 1ps

module exi_bit_packed_integer_writer_top
  import ebpiw_pkg::*;
#(
  parameter int unsigned RAW_WIDTH_MAX = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // action [1:0], value [65:2], raw_len [71:66]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // out_byte [7:0]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  cmd_t    cmd;
  status_t sts;

  ebpiw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .action_i   (s_axis_tdata_i[ActionLsb +: ActionW]),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ebpiw_dp #(
    .RAW_WIDTH_MAX (RAW_WIDTH_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (s_axis_tdata_i[ActionLsb +: ActionW]),
    .value_i     (s_axis_tdata_i[ValueLsb +: ValueW]),
    .raw_len_i   (s_axis_tdata_i[CountLsb +: CountW]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// File: rtl/ebpiw_checker.sv
// Port-level assertion checker for the bit-packed integer writer and its bind.
`timescale 1ns / 1ps
`include "exi_bit_packed_integer_writer_top_macros.svh"

module ebpiw_checker
  import ebpiw_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_i,
  input logic                 m_axis_tvalid_i,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_i,
  input logic                 m_axis_tlast_i
);

  `EBPIW_ASSERT_NEXT(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i), "output transfer changed while stalled")

  `EBPIW_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_i, !s_axis_tready_i, "input ready right after an accepted transfer")

  `EBPIW_ASSERT(a_idle_last, !(s_axis_tready_i && m_axis_tvalid_i) || m_axis_tlast_i, "byte left waiting while idle is not the last of its action")

endmodule

bind exi_bit_packed_integer_writer_top ebpiw_checker u_ebpiw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
